[rtl/bba_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, payload types and helpers for the block bitmap allocator.
package bba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
	localparam int BLK_W      = $clog2(MAX_BLOCKS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int ADDR_W     = BLK_W - BIT_W;
	localparam int LIM_W      = BLK_W + 1;
	localparam int CFG_W      = 13;

	localparam logic [LIM_W-1:0] TOTAL_RST    = LIM_W'(1000);
	localparam logic [BLK_W-1:0] RESERVED_RST = BLK_W'(8);

	// request codes
	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_FORMAT = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// configuration register indexes
	localparam logic CFG_TOTAL    = 1'b0;
	localparam logic CFG_RESERVED = 1'b1;

	localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};
	localparam logic [WORD_BITS-1:0] ONE  = WORD_BITS'(1);

	typedef struct packed {
		logic [1:0]       req_type;
		logic [BLK_W-1:0] block_number;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [BLK_W-1:0] block_number_out;
	} out_word_t;

	typedef struct packed {
		logic                 rd_en;
		logic [ADDR_W-1:0]    rd_addr;
		logic                 wr_en;
		logic [ADDR_W-1:0]    wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} mem_req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE,
		S_FMT
	} state_t;

	// index of the lowest set bit, binary narrowing; all ones for an empty vector
	function automatic logic [BIT_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] cur;
		logic [BIT_W-1:0]     idx;
		cur = v;
		idx = '0;
		for (int k = BIT_W - 1; k >= 0; k--) begin
			if ((cur & (ONES >> (WORD_BITS - (1 << k)))) == '0) begin
				idx[k] = 1'b1;
				cur    = cur >> (1 << k);
			end
		end
		return idx;
	endfunction

endpackage

[rtl/bba_map_mem.sv]
`timescale 1ns / 1ps
// Bitmap store: one-write one-read RAM with per-word valid bits for reset.
module bba_map_mem (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bba_pkg::mem_req_t                mem_req,
	output logic [bba_pkg::WORD_BITS-1:0]    rd_data
);
	import bba_pkg::*;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] valid_q;
	logic [WORD_BITS-1:0] data_s1;
	logic                 vld_s1;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			data_s1 <= mem[mem_req.rd_addr];
		end
	end

	// a word never written since reset reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (mem_req.wr_en) begin
				valid_q[mem_req.wr_addr] <= 1'b1;
			end
			if (mem_req.rd_en) begin
				vld_s1 <= valid_q[mem_req.rd_addr];
			end
		end
	end

	assign rd_data = vld_s1 ? data_s1 : '0;

endmodule

[rtl/bba_ctrl.sv]
`timescale 1ns / 1ps
// Request sequencer: allocate scan, free read-modify-write, format sweep.
module bba_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  bba_pkg::in_word_t             req,
	input  logic [bba_pkg::LIM_W-1:0]     lim,
	input  logic [bba_pkg::BLK_W-1:0]     reserved,
	output logic                          busy,
	output logic                          done,
	output bba_pkg::out_word_t            rsp,
	output bba_pkg::mem_req_t             mem_req,
	input  logic [bba_pkg::WORD_BITS-1:0] rd_data
);
	import bba_pkg::*;

	state_t             state_q, state_d;
	logic [ADDR_W:0]    ptr_q, ptr_d;
	logic [BLK_W-1:0]   blk_q, blk_d;
	logic               chk_vld_s1, chk_vld_d;
	logic [ADDR_W-1:0]  chk_addr_s1;
	logic               done_q, done_d;
	out_word_t          rsp_q, rsp_d;

	logic [LIM_W-1:0]     lim_m1;
	logic [ADDR_W-1:0]    last_word;
	logic [BIT_W-1:0]     last_bit;
	logic [WORD_BITS-1:0] scan_mask;
	logic [WORD_BITS-1:0] free_vec;
	logic [BIT_W-1:0]     free_bit;
	logic [ADDR_W-1:0]    resv_word;
	logic [WORD_BITS-1:0] fmt_word;

	assign lim_m1    = lim - LIM_W'(1);
	assign last_word = lim_m1[BLK_W-1:BIT_W];
	assign last_bit  = lim_m1[BIT_W-1:0];

	// only bits below the limit take part in the last word of the scan
	assign scan_mask = (chk_addr_s1 == last_word)
		? (ONES >> (WORD_BITS - 1 - int'(last_bit))) : ONES;
	assign free_vec  = ~rd_data & scan_mask;
	assign free_bit  = first_one(free_vec);

	assign resv_word = reserved[BLK_W-1:BIT_W];
	always_comb begin
		if (ptr_q[ADDR_W-1:0] < resv_word) begin
			fmt_word = ONES;
		end else if (ptr_q[ADDR_W-1:0] == resv_word) begin
			fmt_word = ONES >> (WORD_BITS - 1 - int'(reserved[BIT_W-1:0]));
		end else begin
			fmt_word = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ptr_q      <= '0;
			chk_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			ptr_q      <= ptr_d;
			chk_vld_s1 <= chk_vld_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		blk_q       <= blk_d;
		chk_addr_s1 <= ptr_q[ADDR_W-1:0];
		rsp_q       <= rsp_d;
	end

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		blk_d     = blk_q;
		chk_vld_d = 1'b0;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		mem_req   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					blk_d = req.block_number;
					ptr_d = '0;
					case (req.req_type)
						REQ_ALLOC: begin
							if (lim == '0) begin
								done_d = 1'b1;
								rsp_d  = '{status: ST_FULL, block_number_out: '0};
							end else begin
								state_d = S_ALLOC;
							end
						end
						REQ_FREE: begin
							if ({1'b0, req.block_number} >= lim) begin
								done_d = 1'b1;
								rsp_d  = '{status: ST_RANGE, block_number_out: '0};
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = req.block_number[BLK_W-1:BIT_W];
								state_d         = S_FREE;
							end
						end
						REQ_FORMAT: begin
							state_d = S_FMT;
						end
						default: begin
							done_d = 1'b1;
							rsp_d  = '{status: ST_OK, block_number_out: '0};
						end
					endcase
				end
			end
			S_ALLOC: begin
				// reads stream one word a cycle; the check works on the registered read word and its address
				if (ptr_q <= {1'b0, last_word}) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = ptr_q[ADDR_W-1:0];
					chk_vld_d       = 1'b1;
					ptr_d           = ptr_q + (ADDR_W+1)'(1);
				end
				if (chk_vld_s1) begin
					if (free_vec != '0) begin
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = chk_addr_s1;
						mem_req.wr_data = rd_data | (ONE << free_bit);
						done_d          = 1'b1;
						rsp_d = '{status: ST_OK, block_number_out: {chk_addr_s1, free_bit}};
						chk_vld_d       = 1'b0;
						state_d         = S_IDLE;
					end else if (chk_addr_s1 == last_word) begin
						done_d    = 1'b1;
						rsp_d     = '{status: ST_FULL, block_number_out: '0};
						chk_vld_d = 1'b0;
						state_d   = S_IDLE;
					end
				end
			end
			S_FREE: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = blk_q[BLK_W-1:BIT_W];
				mem_req.wr_data = rd_data & ~(ONE << blk_q[BIT_W-1:0]);
				done_d          = 1'b1;
				rsp_d           = '{status: ST_OK, block_number_out: '0};
				state_d         = S_IDLE;
			end
			S_FMT: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = ptr_q[ADDR_W-1:0];
				mem_req.wr_data = fmt_word;
				ptr_d           = ptr_q + (ADDR_W+1)'(1);
				if (ptr_q[ADDR_W-1:0] == ADDR_W'(MAP_WORDS - 1)) begin
					done_d  = 1'b1;
					rsp_d   = '{status: ST_OK, block_number_out: '0};
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// the scan writes back a word it already passed, never the one being read
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
		else $error("read and write hit the same map word");

	// a result is only given while the sequencer is idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_chk_in_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (state_q == S_ALLOC))
		else $error("scan check outside allocate");

	// an allocated block lies below the scan limit
	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_OK) |-> ({1'b0, rsp.block_number_out} < lim
			|| rsp.block_number_out == '0))
		else $error("allocated block beyond limit");
`endif

endmodule

[rtl/block_bitmap_allocator_core.sv]
`timescale 1ns / 1ps
// Top level of the block bitmap allocator: configuration registers and wiring.
//
// Usage:
//   Request channel: drive req (req_type, block_number) with start; the word
//   is taken at a rising edge where start is high and busy is low. busy stays
//   high while a request is in progress.
//   Result channel: done pulses for one cycle with rsp (status,
//   block_number_out). The receiver cannot stall it; it must take the word
//   in that cycle. One result word per request.
//   Configuration: cfg_we writes cfg_data into register cfg_idx (0 total
//   block count, 1 reserved block). Write only while idle.
// Request handling:
//   allocate: one bitmap word is read per cycle from the map RAM, in a scan
//   over W words, W up to 128 (block count / 32, rounded up).
//   free: read, modify and write back. Out-of-range free, allocate with a zero
//   block count, and the unused request code answer without a map access.
//   format: one map word written per cycle for all 128 words.
//   One request at a time; the next may start in the cycle done is high.
// Reset: the map reads as all free (per-word valid bits clear at once, no
//   clearing pass); block count = 1000, reserved block = 8.
module block_bitmap_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bba_pkg::in_word_t             req,
	output logic                          done,
	output bba_pkg::out_word_t            rsp,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [bba_pkg::CFG_W-1:0]     cfg_data
);
	import bba_pkg::*;

	logic [LIM_W-1:0]     total_q;
	logic [BLK_W-1:0]     reserved_q;
	logic [LIM_W-1:0]     lim;
	mem_req_t             mem_req;
	logic [WORD_BITS-1:0] rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RST;
			reserved_q <= RESERVED_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TOTAL:    total_q    <= cfg_data[LIM_W-1:0];
				CFG_RESERVED: reserved_q <= cfg_data[BLK_W-1:0];
				default:      ;
			endcase
		end
	end

	// scan limit saturates at the map size
	assign lim = (total_q > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : total_q;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.lim      (lim),
		.reserved (reserved_q),
		.busy     (busy),
		.done     (done),
		.rsp      (rsp),
		.mem_req  (mem_req),
		.rd_data  (rd_data)
	);

	bba_map_mem u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

endmodule
